/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge, ignored while reset is high.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: property does not hold");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

/* src/strun_pkg.sv */
package strun_pkg;

   localparam int BYTE_W   = 8;
   localparam int CHAR_W   = 7;
   localparam int HEXCNT_W = 2;
   localparam int HEXVAL_W = 16;

   localparam logic [BYTE_W-1:0] CTRL_LIMIT  = 8'h20;
   localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;

   localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5c;
   localparam logic [BYTE_W-1:0] CHAR_B = 8'h62;
   localparam logic [BYTE_W-1:0] CHAR_F = 8'h66;
   localparam logic [BYTE_W-1:0] CHAR_N = 8'h6e;
   localparam logic [BYTE_W-1:0] CHAR_R = 8'h72;
   localparam logic [BYTE_W-1:0] CHAR_T = 8'h74;
   localparam logic [BYTE_W-1:0] CHAR_U = 8'h75;

   localparam logic [CHAR_W-1:0] CODE_BS  = 7'h08;
   localparam logic [CHAR_W-1:0] CODE_FF  = 7'h0c;
   localparam logic [CHAR_W-1:0] CODE_LF  = 7'h0a;
   localparam logic [CHAR_W-1:0] CODE_CR  = 7'h0d;
   localparam logic [CHAR_W-1:0] CODE_TAB = 7'h09;

   localparam logic [HEXCNT_W-1:0] HEX_LAST = 2'd3;

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'b001,
      MODE_ESC   = 3'b010,
      MODE_HEX   = 3'b100
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_CHAR  = 3'd1,
      ST_BAD_ESC   = 3'd2,
      ST_BAD_HEX   = 3'd3,
      ST_TOO_LARGE = 3'd4,
      ST_TRUNC     = 3'd5
   } status_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              char_valid;
      logic              end_of_string;
      status_type        status;
   } rsp_type;

endpackage

/* src/strun_req_if.sv */
interface strun_req_if;
   logic                        valid;
   logic                        ready;
   logic [strun_pkg::BYTE_W-1:0] in_byte;
   logic                        is_final;
   logic                        no_byte;

   modport source (output valid, output in_byte, output is_final, output no_byte,
                   input ready);
   modport sink   (input valid, input in_byte, input is_final, input no_byte,
                   output ready);
endinterface

/* src/strun_rsp_if.sv */
interface strun_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [strun_pkg::CHAR_W-1:0] out_char;
   logic                        char_valid;
   logic                        end_of_string;
   strun_pkg::status_type       status;

   modport source (output valid, output out_char, output char_valid,
                   output end_of_string, output status, input ready);
   modport sink   (input valid, input out_char, input char_valid,
                   input end_of_string, input status, output ready);
endinterface

/* src/string_literal_unescaper_unit.sv */
// String literal unescaper: takes the body of a quoted literal one byte per beat and returns
// the unescaped ASCII characters, handling \" \\ \b \f \n \r \t and \u with four hex digits.
// A beat that emits a character, hits an error or carries is_final gives one result beat;
// the others give none. One beat is accepted every cycle while req_chan.ready is high; the
// decode is a single stage, and its result is in an output slot the cycle after acceptance.
// A second output slot lets one more beat in while the sink stalls, so req_chan.ready drops
// only once both slots are full. After an error or a final beat the unit is back in plain
// text mode; a final beat that leaves an escape open reports a truncated escape.
`include "assert_macros.svh"

module string_literal_unescaper_unit (
   input logic        clock,
   input logic        reset,
   strun_req_if.sink  req_chan,
   strun_rsp_if.source rsp_chan
);

   strun_pkg::mode_type                   mode_ff, mode_in;
   logic [strun_pkg::HEXCNT_W-1:0]        hex_count_ff, hex_count_in;
   logic [strun_pkg::HEXVAL_W-1:0]        hex_value_ff, hex_value_in;

   strun_pkg::rsp_type head_ff, head_in, skid_ff, skid_in, result;
   logic head_valid_ff, head_valid_in, skid_valid_ff, skid_valid_in;

   logic                           accept, pop, push, has_result;
   logic                           dig_ok;
   logic [3:0]                     dig_val;
   logic [strun_pkg::HEXVAL_W-1:0] hex_sum;

   assign req_chan.ready = !skid_valid_ff;
   assign accept = req_chan.valid && req_chan.ready;

   // hex digit decode
   always_comb begin
      dig_ok  = 1'b1;
      dig_val = '0;
      if (req_chan.in_byte >= 8'h30 && req_chan.in_byte <= 8'h39) begin
         dig_val = 4'(req_chan.in_byte - 8'h30);
      end else if (req_chan.in_byte >= 8'h41 && req_chan.in_byte <= 8'h46) begin
         dig_val = 4'(req_chan.in_byte - 8'h37);
      end else if (req_chan.in_byte >= 8'h61 && req_chan.in_byte <= 8'h66) begin
         dig_val = 4'(req_chan.in_byte - 8'h57);
      end else begin
         dig_ok = 1'b0;
      end
   end

   // first digit lands in the top nibble
   always_comb begin
      hex_sum = hex_value_ff;
      case (hex_count_ff)
         2'd0:    hex_sum[15:12] = hex_value_ff[15:12] | dig_val;
         2'd1:    hex_sum[11:8]  = hex_value_ff[11:8]  | dig_val;
         2'd2:    hex_sum[7:4]   = hex_value_ff[7:4]   | dig_val;
         default: hex_sum[3:0]   = hex_value_ff[3:0]   | dig_val;
      endcase
   end

   always_comb begin
      mode_in              = mode_ff;
      hex_count_in         = hex_count_ff;
      hex_value_in         = hex_value_ff;
      result.out_char      = '0;
      result.char_valid    = 1'b0;
      result.end_of_string = req_chan.is_final;
      result.status        = strun_pkg::ST_OK;

      if (!req_chan.no_byte) begin
         unique case (mode_ff)
            strun_pkg::MODE_ESC: begin
               mode_in           = strun_pkg::MODE_PLAIN;
               result.char_valid = 1'b1;
               unique case (req_chan.in_byte)
                  strun_pkg::CHAR_QUOTE:  result.out_char = strun_pkg::CHAR_QUOTE[6:0];
                  strun_pkg::CHAR_BSLASH: result.out_char = strun_pkg::CHAR_BSLASH[6:0];
                  strun_pkg::CHAR_B:      result.out_char = strun_pkg::CODE_BS;
                  strun_pkg::CHAR_F:      result.out_char = strun_pkg::CODE_FF;
                  strun_pkg::CHAR_N:      result.out_char = strun_pkg::CODE_LF;
                  strun_pkg::CHAR_R:      result.out_char = strun_pkg::CODE_CR;
                  strun_pkg::CHAR_T:      result.out_char = strun_pkg::CODE_TAB;
                  strun_pkg::CHAR_U: begin
                     result.char_valid = 1'b0;
                     mode_in           = strun_pkg::MODE_HEX;
                     hex_count_in      = '0;
                     hex_value_in      = '0;
                  end
                  default: begin
                     result.char_valid = 1'b0;
                     result.status     = strun_pkg::ST_BAD_ESC;
                  end
               endcase
            end
            strun_pkg::MODE_HEX: begin
               if (!dig_ok) begin
                  result.status = strun_pkg::ST_BAD_HEX;
                  mode_in       = strun_pkg::MODE_PLAIN;
               end else begin
                  hex_value_in = hex_sum;
                  if (hex_count_ff == strun_pkg::HEX_LAST) begin
                     if (|hex_sum[15:7]) begin
                        result.status = strun_pkg::ST_TOO_LARGE;
                     end else begin
                        result.out_char   = hex_sum[6:0];
                        result.char_valid = 1'b1;
                     end
                     mode_in      = strun_pkg::MODE_PLAIN;
                     hex_count_in = '0;
                  end else begin
                     hex_count_in = hex_count_ff + 2'd1;
                  end
               end
            end
            default: begin
               mode_in = strun_pkg::MODE_PLAIN;
               if (req_chan.in_byte < strun_pkg::CTRL_LIMIT ||
                   req_chan.in_byte >= strun_pkg::ASCII_LIMIT) begin
                  result.status = strun_pkg::ST_BAD_CHAR;
               end else if (req_chan.in_byte == strun_pkg::CHAR_BSLASH) begin
                  mode_in = strun_pkg::MODE_ESC;
               end else begin
                  result.out_char   = req_chan.in_byte[6:0];
                  result.char_valid = 1'b1;
               end
            end
         endcase
      end

      if (req_chan.is_final) begin
         if (mode_in != strun_pkg::MODE_PLAIN && result.status == strun_pkg::ST_OK) begin
            result.status = strun_pkg::ST_TRUNC;
         end
         mode_in      = strun_pkg::MODE_PLAIN;
         hex_count_in = '0;
         hex_value_in = '0;
      end
   end

   assign has_result = result.char_valid || result.status != strun_pkg::ST_OK ||
                       req_chan.is_final;
   assign push = accept && has_result;
   assign pop  = head_valid_ff && rsp_chan.ready;

   // two-slot output: head drives the port, skid catches a beat during a stall
   always_comb begin
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!head_valid_ff) begin
         head_in       = result;
         head_valid_in = push;
      end else if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_in       = result;
            head_valid_in = push;
         end
      end else if (push) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= strun_pkg::MODE_PLAIN;
         hex_count_ff  <= '0;
         hex_value_ff  <= '0;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff      <= mode_in;
            hex_count_ff <= hex_count_in;
            hex_value_ff <= hex_value_in;
         end
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid         = head_valid_ff;
   assign rsp_chan.out_char      = head_ff.out_char;
   assign rsp_chan.char_valid    = head_ff.char_valid;
   assign rsp_chan.end_of_string = head_ff.end_of_string;
   assign rsp_chan.status        = head_ff.status;

   `ASSERT_NEVER(skid_without_head, clock, reset, skid_valid_ff && !head_valid_ff)
   `ASSERT_ALWAYS(final_clears_state, clock, reset,
      accept && req_chan.is_final |=> mode_ff == strun_pkg::MODE_PLAIN && hex_count_ff == '0)
   `ASSERT_ALWAYS(char_only_when_ok, clock, reset,
      rsp_chan.valid && rsp_chan.char_valid |-> rsp_chan.status == strun_pkg::ST_OK)
   `ASSERT_ALWAYS(no_char_is_zero, clock, reset,
      rsp_chan.valid && !rsp_chan.char_valid |-> rsp_chan.out_char == '0)

endmodule
